### design/hdpf_pkg.sv
`timescale 1ns / 1ps
package hdpf_pkg;

  localparam int POS_FRAC_BITS_DEF = 16;
  localparam int POS_INT_BITS_DEF  = 8;
  localparam int BOX_W             = 8;
  localparam int CFG_ADDR_W        = 2;
  localparam int BOX_HEIGHT_RST    = 16;
  localparam int STIFFNESS_RST     = 65536;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BOX_HEIGHT = 2'd0,
    REG_STIFFNESS  = 2'd1,
    REG_RAMP_START = 2'd2,
    REG_RAMP_END   = 2'd3
  } hdpf_reg_t;

  typedef struct packed {
    logic contact;
    logic coinc;
    logic pos_x;
    logic pos_y;
    logic band1;
    logic band2;
  } hdpf_flags_t;

endpackage

### design/hdpf_in_if.sv
`timescale 1ns / 1ps
interface hdpf_in_if #(
  parameter int W = 24
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] first_x;
  logic [W-1:0] first_y;
  logic [W-1:0] second_x;
  logic [W-1:0] second_y;

  modport source (output valid, first_x, first_y, second_x, second_y, input ready);
  modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

### design/hdpf_out_if.sv
`timescale 1ns / 1ps
interface hdpf_out_if #(
  parameter int W = 24
) ();
  logic                valid;
  logic                ready;
  logic signed [W:0]   force_x;
  logic signed [W:0]   force_y;
  logic        [W-1:0] pair_energy;
  logic                in_contact;
  logic                coincident;

  modport source (output valid, force_x, force_y, pair_energy, in_contact, coincident,
                  input ready);
  modport sink   (input valid, force_x, force_y, pair_energy, in_contact, coincident,
                  output ready);
endinterface

### design/hdpf_cfg_if.sv
`timescale 1ns / 1ps
interface hdpf_cfg_if #(
  parameter int AW = 2,
  parameter int DW = 24
) ();
  logic          valid;
  logic          ready;
  logic [AW-1:0] addr;
  logic [DW-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

### design/harmonic_disk_pair_force_top.sv
`timescale 1ns / 1ps
// Harmonic soft-disk pair force. Takes one disk pair per clock unless stalled and
// returns the force on the first disk, the energy added to each disk and the
// contact and coincidence flags, in order, one result per pair. The pipeline is
// fully pipelined: a new pair may be transferred every cycle unless stalled. It
// holds the bit-per-stage square root (F stages), the stiffness ramp divider
// (W stages) and the force divider (W+1 stages), with W = POS_INT_BITS +
// POS_FRAC_BITS and F = POS_FRAC_BITS (Q8.16 by default). The pipeline only
// stalls when its last stage holds a result and the output register is full and
// not being taken.
// Configuration writes are always ready and must be made while the block is idle.
module harmonic_disk_pair_force_top import hdpf_pkg::*; #(
  parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF,
  parameter int POS_INT_BITS  = POS_INT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  hdpf_in_if.sink     in_ch,
  hdpf_out_if.source  out_ch,
  hdpf_cfg_if.sink    cfg_ch
);

  localparam int W    = POS_INT_BITS + POS_FRAC_BITS;
  localparam int F    = POS_FRAC_BITS;
  localparam int FL_W = $bits(hdpf_flags_t);
  localparam int SB1_W = FL_W + 2 * F + 2 * W;
  localparam int SB2_W = FL_W + 3 * F;
  localparam int SB3_W = FL_W + W;
  localparam logic [F:0] ONE_V = (F+1)'(1) << F;

  // configuration
  logic [BOX_W-1:0] box_height_r;
  logic [W-1:0]     stiffness_r, ramp_start_r, ramp_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_height_r <= BOX_W'(BOX_HEIGHT_RST);
      stiffness_r  <= W'(STIFFNESS_RST);
      ramp_start_r <= '0;
      ramp_end_r   <= '1;
    end else if (cfg_ch.valid) begin
      case (hdpf_reg_t'(cfg_ch.addr))
        REG_BOX_HEIGHT: box_height_r <= cfg_ch.data[BOX_W-1:0];
        REG_STIFFNESS:  stiffness_r  <= cfg_ch.data[W-1:0];
        REG_RAMP_START: ramp_start_r <= cfg_ch.data[W-1:0];
        REG_RAMP_END:   ramp_end_r   <= cfg_ch.data[W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  // pipeline enable
  logic en;
  logic fv;
  logic out_valid_r;

  assign en           = !(fv && out_valid_r && !out_ch.ready);
  assign in_ch.ready  = en;

  // separation, wrap, squared distance
  logic           fr_v;
  hdpf_flags_t    fr_fl;
  logic [F-1:0]   fr_mx, fr_my;
  logic [W-1:0]   fr_b1, fr_b2;
  logic [2*F-1:0] fr_r2;

  hdpf_front #(
    .POS_FRAC_BITS (POS_FRAC_BITS),
    .POS_INT_BITS  (POS_INT_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_ch.valid),
    .x1         (in_ch.first_x),
    .y1         (in_ch.first_y),
    .x2         (in_ch.second_x),
    .y2         (in_ch.second_y),
    .box_height (box_height_r),
    .ramp_start (ramp_start_r),
    .ramp_end   (ramp_end_r),
    .out_valid  (fr_v),
    .flags      (fr_fl),
    .mx         (fr_mx),
    .my         (fr_my),
    .b1         (fr_b1),
    .b2         (fr_b2),
    .r2         (fr_r2)
  );

  // distance
  logic             sq_v;
  logic [F-1:0]     sq_r;
  logic [SB1_W-1:0] sq_sb;
  hdpf_flags_t      sq_fl;
  logic [F-1:0]     sq_mx, sq_my;
  logic [W-1:0]     sq_b1, sq_b2;

  hdpf_isqrt #(
    .R    (F),
    .SB_W (SB1_W)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_v),
    .v         (fr_r2),
    .in_sb     ({fr_fl, fr_mx, fr_my, fr_b1, fr_b2}),
    .out_valid (sq_v),
    .root      (sq_r),
    .out_sb    (sq_sb)
  );

  assign {sq_fl, sq_mx, sq_my, sq_b1, sq_b2} = sq_sb;

  // ramped stiffness of each disk
  logic             st_v;
  logic [W-1:0]     st_k1, st_k2;
  logic [SB2_W-1:0] st_sb;
  hdpf_flags_t      st_fl;
  logic [F-1:0]     st_mx, st_my, st_r;

  hdpf_muldiv2 #(
    .A_W  (W),
    .C_W  (W),
    .SB_W (SB2_W)
  ) u_stiff (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_v),
    .a         (stiffness_r),
    .b0        (sq_b1),
    .b1        (sq_b2),
    .c         (ramp_end_r - ramp_start_r),
    .in_sb     ({sq_fl, sq_mx, sq_my, sq_r}),
    .out_valid (st_v),
    .q0        (st_k1),
    .q1        (st_k2),
    .out_sb    (st_sb)
  );

  assign {st_fl, st_mx, st_my, st_r} = st_sb;

  // a = S * (1 - r)
  logic [W-1:0]       k1, k2;
  logic [W:0]         s_sum;
  logic [F:0]         omr;
  logic [W+F+1:0]     a_prod;
  logic               sa_v_r;
  logic [W:0]         sa_a_r;
  logic [F:0]         sa_omr_r;
  hdpf_flags_t        sa_fl_r;
  logic [F-1:0]       sa_mx_r, sa_my_r, sa_rt_r;

  assign k1     = st_fl.band1 ? st_k1 : stiffness_r;
  assign k2     = st_fl.band2 ? st_k2 : stiffness_r;
  assign s_sum  = {1'b0, k1} + {1'b0, k2};
  assign omr    = ONE_V - {1'b0, st_r};
  assign a_prod = s_sum * omr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_v_r <= 1'b0;
    end else if (en) begin
      sa_v_r <= st_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_a_r   <= a_prod[F +: W+1];
      sa_omr_r <= omr;
      sa_fl_r  <= st_fl;
      sa_mx_r  <= st_mx;
      sa_my_r  <= st_my;
      sa_rt_r  <= st_r;
    end
  end

  // energy and force magnitudes
  logic [W+F+1:0]   e_prod;
  logic [SB3_W-1:0] fd_sb;
  logic [W:0]       fd_qx, fd_qy;
  hdpf_flags_t      fd_fl;
  logic [W-1:0]     fd_e;

  assign e_prod = sa_a_r * sa_omr_r;

  hdpf_muldiv2 #(
    .A_W  (W + 1),
    .C_W  (F + 1),
    .SB_W (SB3_W)
  ) u_force (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sa_v_r),
    .a         (sa_a_r),
    .b0        ({1'b0, sa_mx_r}),
    .b1        ({1'b0, sa_my_r}),
    .c         ({sa_rt_r, 1'b0}),
    .in_sb     ({sa_fl_r, e_prod[F+2 +: W]}),
    .out_valid (fv),
    .q0        (fd_qx),
    .q1        (fd_qy),
    .out_sb    (fd_sb)
  );

  assign {fd_fl, fd_e} = fd_sb;

  // output register
  logic signed [W:0] fx_r, fy_r;
  logic [W-1:0]      en_r;
  logic              cont_r, coin_r;
  logic              push;

  assign push = fd_fl.contact && !fd_fl.coinc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= fv;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      fx_r   <= !push ? '0 : (fd_fl.pos_x ? -$signed(fd_qx) : $signed(fd_qx));
      fy_r   <= !push ? '0 : (fd_fl.pos_y ? -$signed(fd_qy) : $signed(fd_qy));
      en_r   <= fd_fl.contact ? fd_e : '0;
      cont_r <= fd_fl.contact;
      coin_r <= fd_fl.contact && fd_fl.coinc;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.force_x     = fx_r;
  assign out_ch.force_y     = fy_r;
  assign out_ch.pair_energy = en_r;
  assign out_ch.in_contact  = cont_r;
  assign out_ch.coincident  = coin_r;

endmodule

### design/hdpf_front.sv
`timescale 1ns / 1ps
module hdpf_front import hdpf_pkg::*; #(
  parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF,
  parameter int POS_INT_BITS  = POS_INT_BITS_DEF,
  localparam int W = POS_INT_BITS + POS_FRAC_BITS,
  localparam int F = POS_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [W-1:0]      x1,
  input  logic [W-1:0]      y1,
  input  logic [W-1:0]      x2,
  input  logic [W-1:0]      y2,
  input  logic [BOX_W-1:0]  box_height,
  input  logic [W-1:0]      ramp_start,
  input  logic [W-1:0]      ramp_end,
  output logic              out_valid,
  output hdpf_flags_t       flags,
  output logic [F-1:0]      mx,
  output logic [F-1:0]      my,
  output logic [W-1:0]      b1,
  output logic [W-1:0]      b2,
  output logic [2*F-1:0]    r2
);

  localparam int SW = (((W + 2) > (BOX_W + F + 1)) ? (W + 2) : (BOX_W + F + 1)) + 1;
  localparam logic [SW-1:0] ONE_V = SW'(1) << F;

  logic signed [SW-1:0] dx_s, dy_s, dyw_s, h_s, one_s, ax_s, ay_s;
  logic                 near;

  // stage 1 registers
  logic          v1_r, near1_r, px1_r, py1_r, bd1_r, bd2_r;
  logic [F-1:0]  mx1_r, my1_r;
  logic [W-1:0]  b11_r, b21_r;
  // stage 2 registers
  logic          v2_r, near2_r, px2_r, py2_r, bd12_r, bd22_r;
  logic [F-1:0]  mx2_r, my2_r;
  logic [W-1:0]  b12_r, b22_r;
  logic [2*F-1:0] sqx_r, sqy_r;
  // stage 3 registers
  logic           v3_r;
  hdpf_flags_t    fl3_r;
  logic [F-1:0]   mx3_r, my3_r;
  logic [W-1:0]   b13_r, b23_r;
  logic [2*F-1:0] r23_r;
  logic [2*F:0]   sum;

  always_comb begin
    dx_s  = $signed(SW'(x2)) - $signed(SW'(x1));
    dy_s  = $signed(SW'(y2)) - $signed(SW'(y1));
    h_s   = $signed(SW'({box_height, {F{1'b0}}}));
    one_s = $signed(ONE_V);
    if ((dy_s <<< 1) > h_s) begin
      dyw_s = dy_s - h_s;
    end else if ((dy_s <<< 1) < -h_s) begin
      dyw_s = dy_s + h_s;
    end else begin
      dyw_s = dy_s;
    end
    near = (dx_s < one_s) && (dx_s > -one_s) && (dyw_s < one_s) && (dyw_s > -one_s) &&
           (x1 < ramp_end) && (x2 < ramp_end);
    ax_s = dx_s[SW-1] ? -dx_s : dx_s;
    ay_s = dyw_s[SW-1] ? -dyw_s : dyw_s;
  end

  assign sum = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      near1_r <= near;
      px1_r   <= (dx_s > 0);
      py1_r   <= (dyw_s > 0);
      bd1_r   <= (ramp_start < x1) && (x1 < ramp_end);
      bd2_r   <= (ramp_start < x2) && (x2 < ramp_end);
      mx1_r   <= ax_s[F-1:0];
      my1_r   <= ay_s[F-1:0];
      b11_r   <= ramp_end - x1;
      b21_r   <= ramp_end - x2;

      near2_r <= near1_r;
      px2_r   <= px1_r;
      py2_r   <= py1_r;
      bd12_r  <= bd1_r;
      bd22_r  <= bd2_r;
      mx2_r   <= mx1_r;
      my2_r   <= my1_r;
      b12_r   <= b11_r;
      b22_r   <= b21_r;
      sqx_r   <= mx1_r * mx1_r;
      sqy_r   <= my1_r * my1_r;

      fl3_r.contact <= near2_r && !sum[2*F];
      fl3_r.coinc   <= near2_r && (sum == '0);
      fl3_r.pos_x   <= px2_r;
      fl3_r.pos_y   <= py2_r;
      fl3_r.band1   <= bd12_r;
      fl3_r.band2   <= bd22_r;
      mx3_r <= mx2_r;
      my3_r <= my2_r;
      b13_r <= b12_r;
      b23_r <= b22_r;
      r23_r <= sum[2*F-1:0];
    end
  end

  assign out_valid = v3_r;
  assign flags     = fl3_r;
  assign mx        = mx3_r;
  assign my        = my3_r;
  assign b1        = b13_r;
  assign b2        = b23_r;
  assign r2        = r23_r;

endmodule

### design/hdpf_isqrt.sv
`timescale 1ns / 1ps
module hdpf_isqrt #(
  parameter int R    = 16,
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*R-1:0]  v,
  input  logic [SB_W-1:0] in_sb,
  output logic            out_valid,
  output logic [R-1:0]    root,
  output logic [SB_W-1:0] out_sb
);

  logic [R-1:0]    vld_r;
  logic [R:0]      rem_r [R];
  logic [R-1:0]    q_r   [R];
  logic [2*R-1:0]  rad_r [R];
  logic [SB_W-1:0] sb_r  [R];

  for (genvar i = 0; i < R; i++) begin : g_stage
    logic            pv;
    logic [R:0]      prem;
    logic [R-1:0]    pq;
    logic [2*R-1:0]  prad;
    logic [SB_W-1:0] psb;
    logic [R+2:0]    rsh, trial;

    if (i == 0) begin : g_first
      assign pv   = in_valid;
      assign prem = '0;
      assign pq   = '0;
      assign prad = v;
      assign psb  = in_sb;
    end else begin : g_next
      assign pv   = vld_r[i-1];
      assign prem = rem_r[i-1];
      assign pq   = q_r[i-1];
      assign prad = rad_r[i-1];
      assign psb  = sb_r[i-1];
    end

    assign rsh   = {prem, prad[2*R-1:2*R-2]};
    assign trial = (R+3)'({pq, 2'b01});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rsh >= trial) begin
          rem_r[i] <= (R+1)'(rsh - trial);
          q_r[i]   <= {pq[R-2:0], 1'b1};
        end else begin
          rem_r[i] <= rsh[R:0];
          q_r[i]   <= {pq[R-2:0], 1'b0};
        end
        rad_r[i] <= {prad[2*R-3:0], 2'b00};
        sb_r[i]  <= psb;
      end
    end
  end

  assign out_valid = vld_r[R-1];
  assign root      = q_r[R-1];
  assign out_sb    = sb_r[R-1];

endmodule

### design/hdpf_muldiv2.sv
`timescale 1ns / 1ps
module hdpf_muldiv2 #(
  parameter int A_W  = 24,
  parameter int C_W  = 24,
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [A_W-1:0]  a,
  input  logic [C_W-1:0]  b0,
  input  logic [C_W-1:0]  b1,
  input  logic [C_W-1:0]  c,
  input  logic [SB_W-1:0] in_sb,
  output logic            out_valid,
  output logic [A_W-1:0]  q0,
  output logic [A_W-1:0]  q1,
  output logic [SB_W-1:0] out_sb
);

  // one bit of a per stage: floor(a*b/c) for b < c
  function automatic logic [A_W+C_W-1:0] md_step(input logic [C_W-1:0] rem,
                                                 input logic [A_W-1:0] q,
                                                 input logic           abit,
                                                 input logic [C_W-1:0] b,
                                                 input logic [C_W-1:0] cc);
    logic [C_W:0]   t;
    logic [A_W-1:0] nq;
    t  = {rem, 1'b0};
    nq = {q[A_W-2:0], 1'b0};
    if (t >= {1'b0, cc}) begin
      t  = t - {1'b0, cc};
      nq = nq + A_W'(1);
    end
    if (abit) begin
      t = t + {1'b0, b};
      if (t >= {1'b0, cc}) begin
        t  = t - {1'b0, cc};
        nq = nq + A_W'(1);
      end
    end
    return {nq, t[C_W-1:0]};
  endfunction

  logic [A_W-1:0]  vld_r;
  logic [A_W-1:0]  a_r   [A_W];
  logic [C_W-1:0]  b0_r  [A_W];
  logic [C_W-1:0]  b1_r  [A_W];
  logic [C_W-1:0]  c_r   [A_W];
  logic [A_W-1:0]  q0_r  [A_W];
  logic [A_W-1:0]  q1_r  [A_W];
  logic [C_W-1:0]  rm0_r [A_W];
  logic [C_W-1:0]  rm1_r [A_W];
  logic [SB_W-1:0] sb_r  [A_W];

  for (genvar i = 0; i < A_W; i++) begin : g_stage
    logic            pv;
    logic [A_W-1:0]  pa, pq0, pq1;
    logic [C_W-1:0]  pb0, pb1, pc, prm0, prm1;
    logic [SB_W-1:0] psb;
    logic [A_W+C_W-1:0] n0, n1;

    if (i == 0) begin : g_first
      assign pv   = in_valid;
      assign pa   = a;
      assign pb0  = b0;
      assign pb1  = b1;
      assign pc   = c;
      assign pq0  = '0;
      assign pq1  = '0;
      assign prm0 = '0;
      assign prm1 = '0;
      assign psb  = in_sb;
    end else begin : g_next
      assign pv   = vld_r[i-1];
      assign pa   = a_r[i-1];
      assign pb0  = b0_r[i-1];
      assign pb1  = b1_r[i-1];
      assign pc   = c_r[i-1];
      assign pq0  = q0_r[i-1];
      assign pq1  = q1_r[i-1];
      assign prm0 = rm0_r[i-1];
      assign prm1 = rm1_r[i-1];
      assign psb  = sb_r[i-1];
    end

    assign n0 = md_step(prm0, pq0, pa[A_W-1], pb0, pc);
    assign n1 = md_step(prm1, pq1, pa[A_W-1], pb1, pc);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_r[i]   <= {pa[A_W-2:0], 1'b0};
        b0_r[i]  <= pb0;
        b1_r[i]  <= pb1;
        c_r[i]   <= pc;
        q0_r[i]  <= n0[A_W+C_W-1:C_W];
        rm0_r[i] <= n0[C_W-1:0];
        q1_r[i]  <= n1[A_W+C_W-1:C_W];
        rm1_r[i] <= n1[C_W-1:0];
        sb_r[i]  <= psb;
      end
    end
  end

  assign out_valid = vld_r[A_W-1];
  assign q0        = q0_r[A_W-1];
  assign q1        = q1_r[A_W-1];
  assign out_sb    = sb_r[A_W-1];

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import hdpf_pkg::*;

  localparam int F = POS_FRAC_BITS_DEF;
  localparam int W = POS_INT_BITS_DEF + POS_FRAC_BITS_DEF;
  localparam longint ONE = 64'd1 << F;
  localparam longint PMASK = (64'd1 << W) - 1;
  localparam longint FMASK = (64'd1 << (W + 1)) - 1;
  localparam int LAT = 2 * W + F + 6;

  typedef struct packed {
    logic [W-1:0] x1;
    logic [W-1:0] y1;
    logic [W-1:0] x2;
    logic [W-1:0] y2;
  } pair_t;

  typedef struct packed {
    logic [W:0]   fx;
    logic [W:0]   fy;
    logic [W-1:0] en;
    logic         contact;
    logic         coinc;
  } force_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hdpf_in_if  #(.W(W)) in_ch ();
  hdpf_out_if #(.W(W)) out_ch ();
  hdpf_cfg_if #(.AW(CFG_ADDR_W), .DW(W)) cfg_ch ();

  harmonic_disk_pair_force_top uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  longint box_h, k_spring, r_start, r_end;

  pair_t      pending_pairs[$];
  force_res_t expected_forces[$];
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  hold_cycles = 0;
  bit  failed = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint scaled_div(longint a, longint b, longint c);
    longint q, rem;
    q = 0;
    rem = 0;
    for (int i = W - 1; i >= 0; i--) begin
      q = q << 1;
      rem = rem << 1;
      if (rem >= c) begin
        rem -= c;
        q++;
      end
      if ((a >> i) & 1) begin
        rem += b;
        if (rem >= c) begin
          rem -= c;
          q++;
        end
      end
    end
    return q;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint disk_k(longint x);
    if (r_start < x && x < r_end) return scaled_div(k_spring, r_end - x, r_end - r_start);
    return k_spring;
  endfunction

  function automatic logic [W:0] comp_force(longint d, longint a, longint r);
    longint mag, f;
    mag = (d < 0) ? -d : d;
    f = (a * mag) / (r << 1);
    if (f > (PMASK >> 1) + (64'd1 << (W - 1)) - 1) f = PMASK;
    if (f > PMASK) f = PMASK;
    if (d > 0) return (W+1)'((-f) & FMASK);
    return (W+1)'(f & FMASK);
  endfunction

  function automatic force_res_t pair_force(pair_t p);
    force_res_t res;
    longint dx, dy, h, r2, r, s, a;
    res = '0;
    dx = longint'(p.x2) - longint'(p.x1);
    dy = longint'(p.y2) - longint'(p.y1);
    h = box_h << F;
    if (2 * dy > h) dy -= h;
    else if (2 * dy < -h) dy += h;
    if (dx >= ONE || dx <= -ONE || dy >= ONE || dy <= -ONE) return res;
    if (p.x1 >= r_end || p.x2 >= r_end) return res;
    r2 = dx * dx + dy * dy;
    if (r2 >= ONE * ONE) return res;
    r = int_sqrt(r2);
    s = disk_k(p.x1) + disk_k(p.x2);
    a = (s * (ONE - r)) >> F;
    res.contact = 1'b1;
    if (r2 == 0) res.coinc = 1'b1;
    else begin
      res.fx = comp_force(dx, a, r);
      res.fy = comp_force(dy, a, r);
    end
    res.en = W'(((a * (ONE - r)) >> (F + 2)) & PMASK);
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        pair_t p;
        p = pending_pairs.pop_front();
        expected_forces.push_back(pair_force(p));
        in_ch.valid <= 1'b1;
        {in_ch.first_x, in_ch.first_y, in_ch.second_x, in_ch.second_y} <= p;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // long hold-off counted here
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      force_res_t got, exp;
      got = {out_ch.force_x, out_ch.force_y, out_ch.pair_energy,
             out_ch.in_contact, out_ch.coincident};
      if (expected_forces.size() == 0) begin
        $display("%0t: unexpected transfer, actual %h", $time, got);
        failed = 1;
      end else begin
        exp = expected_forces.pop_front();
        if (got.fx !== exp.fx) begin
          $display("%0t: force_x expected %h actual %h", $time, exp.fx, got.fx);
          failed = 1;
        end
        if (got.fy !== exp.fy) begin
          $display("%0t: force_y expected %h actual %h", $time, exp.fy, got.fy);
          failed = 1;
        end
        if (got.en !== exp.en) begin
          $display("%0t: pair_energy expected %h actual %h", $time, exp.en, got.en);
          failed = 1;
        end
        if (got.contact !== exp.contact) begin
          $display("%0t: in_contact expected %b actual %b", $time, exp.contact,
                   got.contact);
          failed = 1;
        end
        if (got.coinc !== exp.coinc) begin
          $display("%0t: coincident expected %b actual %b", $time, exp.coinc, got.coinc);
          failed = 1;
        end
      end
    end
  end

  task automatic write_reg(hdpf_reg_t idx, longint val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr <= idx;
    cfg_ch.data <= val[W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_BOX_HEIGHT: box_h = val & 8'hFF;
      REG_STIFFNESS:  k_spring = val & PMASK;
      REG_RAMP_START: r_start = val & PMASK;
      default:        r_end = val & PMASK;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_pairs.size() > 0 || expected_forces.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
  endtask

  function automatic longint rnd_pos();
    return {$urandom(), $urandom()} & PMASK;
  endfunction

  function automatic longint near_pos(longint base, longint spread);
    longint v;
    v = base + longint'($urandom_range(2 * spread)) - spread;
    return v & PMASK;
  endfunction

  task automatic add_pair(longint x1, longint y1, longint x2, longint y2);
    pair_t p;
    p.x1 = x1[W-1:0];
    p.y1 = y1[W-1:0];
    p.x2 = x2[W-1:0];
    p.y2 = y2[W-1:0];
    pending_pairs.push_back(p);
  endtask

  task automatic add_random(int n);
    longint x1, y1, h;
    repeat (n) begin
      x1 = rnd_pos();
      y1 = rnd_pos();
      h = (box_h == 0 ? 256 : box_h) << F;
      case ($urandom_range(9))
        0: add_pair(x1, y1, rnd_pos(), rnd_pos());
        1: add_pair(x1, y1, x1, y1);
        2: add_pair(x1, y1 % h, near_pos(x1, ONE), (y1 % h + h - $urandom_range(ONE)) % h);
        default: add_pair(x1, y1, near_pos(x1, ONE), near_pos(y1, ONE));
      endcase
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.first_x = '0;
    in_ch.first_y = '0;
    in_ch.second_x = '0;
    in_ch.second_y = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = REG_BOX_HEIGHT;
    cfg_ch.data = '0;
    box_h = BOX_HEIGHT_RST;
    k_spring = STIFFNESS_RST;
    r_start = 0;
    r_end = PMASK;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    add_pair(0, 0, 0, 0);
    add_pair(PMASK, PMASK, PMASK, PMASK);
    add_pair(100, 100, 100 + ONE - 1, 100);
    add_pair(100, 100, 100 + ONE, 100);
    add_pair(ONE, ONE, 0, ONE);
    add_pair(5 * ONE, 5 * ONE, 5 * ONE + ONE / 2, 5 * ONE + ONE / 3);
    add_pair(5 * ONE, 0, 5 * ONE, 16 * ONE - ONE / 4);
    add_pair(5 * ONE, 16 * ONE - 10, 5 * ONE, 20);
    add_pair(0, 0, 1, 1);
    add_pair(PMASK, 0, PMASK - 3, 0);
    add_pair(0, PMASK, ONE - 1, PMASK);
    add_pair(3 * ONE, 7 * ONE, 3 * ONE - ONE / 2, 7 * ONE - ONE / 2);
    drain();

    write_reg(REG_BOX_HEIGHT, 0);
    write_reg(REG_STIFFNESS, PMASK);
    write_reg(REG_RAMP_START, 10 * ONE);
    write_reg(REG_RAMP_END, 12 * ONE);
    add_pair(11 * ONE, 0, 11 * ONE + 100, 0);
    add_pair(12 * ONE - 1, 0, 12 * ONE - 2, 50);
    add_pair(12 * ONE, 0, 12 * ONE - 2, 50);
    add_pair(10 * ONE, 0, 10 * ONE + 7, 0);
    add_pair(5 * ONE, 0, 5 * ONE, PMASK);
    add_pair(11 * ONE, 3, 11 * ONE, 3);
    for (int i = 0; i < 60; i++) add_pair(10 * ONE + 1000 * i, i, 10 * ONE + 999 * i, 7 * i);
    send_idle_pct = 14;
    recv_idle_pct = 55;
    add_random(200);
    drain();

    write_reg(REG_BOX_HEIGHT, 255);
    write_reg(REG_STIFFNESS, 0);
    write_reg(REG_RAMP_START, PMASK);
    write_reg(REG_RAMP_END, 0);
    add_random(40);
    drain();

    write_reg(REG_BOX_HEIGHT, 1);
    write_reg(REG_STIFFNESS, 3 * ONE + 12345);
    write_reg(REG_RAMP_START, 20 * ONE);
    write_reg(REG_RAMP_END, 200 * ONE);
    send_idle_pct = 55;
    recv_idle_pct = 14;
    add_random(200);
    drain();

    write_reg(REG_BOX_HEIGHT, 1 + $urandom_range(254));
    write_reg(REG_STIFFNESS, rnd_pos());
    write_reg(REG_RAMP_START, rnd_pos() >> 1);
    write_reg(REG_RAMP_END, PMASK);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(150);
    hold_cycles = 400;
    add_random(150);
    drain();

    if (!failed) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
